@@ hw/rtl/radius_gated_track_matcher_assert.svh @@
// ----------------------------------------------------------------------------
// radius_gated_track_matcher assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while synchronous reset is low.
// ----------------------------------------------------------------------------
`ifndef RADIUS_GATED_TRACK_MATCHER_ASSERT_SVH
`define RADIUS_GATED_TRACK_MATCHER_ASSERT_SVH

// same-cycle implication
`define RGTM_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RGTM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/rgtm_pkg.sv @@
// ----------------------------------------------------------------------------
// rgtm_pkg
// Types and constants of the radius-gated track matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package rgtm_pkg;

  localparam int FIELD_W    = 12;
  localparam int SIZE_W     = 12;
  localparam int FRAME_W    = 16;
  localparam int IDX_W      = 4;
  localparam int RESULT_CAP = 16;

  localparam int DEF_MAX_TRACKS     = 16;
  localparam int DEF_MAX_DETECTIONS = 64;
  localparam int DEF_COORD_BITS     = 12;

  localparam logic [2:0]         ADDR_FRAME_LIMIT = 3'd0;
  localparam logic [FRAME_W-1:0] FRAME_LIMIT_RST  = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_START     = 2'd0,
    OP_ADD_TRACK = 2'd1,
    OP_ADD_DET   = 2'd2,
    OP_END_FRAME = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    STAT_TRACKED   = 3'd0,
    STAT_MISMATCH  = 3'd1,
    STAT_LIMIT     = 3'd2,
    STAT_HALTED    = 3'd3,
    STAT_NO_TRACKS = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SRCH_RD,
    FSM_SRCH_WAIT,
    FSM_SRCH_GATE,
    FSM_UPD_RD,
    FSM_UPD_WR,
    FSM_EMIT
  } fsm_state_t;

  typedef enum logic [2:0] {
    GP_IDLE,
    GP_SQX,
    GP_SQY,
    GP_SQR,
    GP_CMP
  } gate_phase_t;

  typedef struct packed {
    logic done;
    logic hit;
  } gate_res_t;

endpackage

`default_nettype wire

@@ hw/rtl/rgtm_gate.sv @@
// ----------------------------------------------------------------------------
// rgtm_gate
// Radius gate: dx^2 + dy^2 <= r^2 through one shared squarer, one square
// per cycle, result valid for one cycle in the compare phase.
// ----------------------------------------------------------------------------
`default_nettype none

module rgtm_gate
  import rgtm_pkg::*;
#(
  parameter int CW = DEF_COORD_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [CW-1:0]     trk_x,
  input  wire logic [CW-1:0]     trk_y,
  input  wire logic [SIZE_W-1:0] trk_size,
  input  wire logic [CW-1:0]     det_x,
  input  wire logic [CW-1:0]     det_y,
  output gate_res_t              res
);

  localparam int PW = 2 * SIZE_W;

  gate_phase_t       ph_r, ph_nxt;
  logic [SIZE_W-1:0] dx_r, dy_r, r_r;
  logic [SIZE_W-1:0] op;
  logic [PW-1:0]     prod_r;
  logic [PW:0]       sum_r;
  logic [CW-1:0]     dx, dy;

  assign dx = (trk_x > det_x) ? (trk_x - det_x) : (det_x - trk_x);
  assign dy = (trk_y > det_y) ? (trk_y - det_y) : (det_y - trk_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= GP_IDLE;
    end else begin
      ph_r <= ph_nxt;
    end
  end

  always_comb begin
    ph_nxt = ph_r;
    unique case (ph_r)
      GP_IDLE: if (start) ph_nxt = GP_SQX;
      GP_SQX:  ph_nxt = GP_SQY;
      GP_SQY:  ph_nxt = GP_SQR;
      GP_SQR:  ph_nxt = GP_CMP;
      GP_CMP:  ph_nxt = GP_IDLE;
      default: ph_nxt = GP_IDLE;
    endcase
  end

  always_comb begin
    case (ph_r)
      GP_SQX:  op = dx_r;
      GP_SQY:  op = dy_r;
      default: op = r_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ph_r == GP_IDLE && start) begin
      dx_r <= SIZE_W'(dx);
      dy_r <= SIZE_W'(dy);
      r_r  <= trk_size;
    end
    if (ph_r == GP_SQX || ph_r == GP_SQY || ph_r == GP_SQR) begin
      prod_r <= PW'(op) * PW'(op);
    end
    if (ph_r == GP_SQY) begin
      sum_r <= {1'b0, prod_r};
    end else if (ph_r == GP_SQR) begin
      sum_r <= sum_r + {1'b0, prod_r};
    end
  end

  assign res.done = (ph_r == GP_CMP);
  assign res.hit  = (sum_r <= {1'b0, prod_r});

endmodule

`default_nettype wire

@@ hw/rtl/radius_gated_track_matcher.sv @@
// ----------------------------------------------------------------------------
// radius_gated_track_matcher
// Frame-to-frame blob tracker with radius gating on squared distance.
// ----------------------------------------------------------------------------
// Start, add-track and add-detection beats are taken one per cycle while
// idle. An end-of-frame beat walks every track against the buffered
// detections in order; each track/detection comparison reads both stores,
// then the shared squarer forms dx^2, dy^2 and r^2 one per cycle before
// the compare. A fully matched frame then reads each track's match, copies
// it into the track store and emits up to 16 result beats. Single-result
// statuses (halted, frame limit, no tracks, mismatch) are emitted as one
// beat. The input stays not-ready for the whole end-of-frame walk; output
// stalls add directly to it. Stores need no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "radius_gated_track_matcher_assert.svh"

module radius_gated_track_matcher
  import rgtm_pkg::*;
#(
  parameter int MAX_TRACKS     = DEF_MAX_TRACKS,
  parameter int MAX_DETECTIONS = DEF_MAX_DETECTIONS,
  parameter int COORD_BITS     = DEF_COORD_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input beats
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,   // start_frame, pos_x, pos_y, blob_size
  input  wire logic [1:0]  in_tuser,   // opcode
  // result beats
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // track_index, match_x, match_y,
                                       // match_size, frame_number
  output logic [2:0]       out_tuser,  // status
  output logic             out_tlast,
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int CW  = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int BW  = 2 * CW + SIZE_W;
  localparam int TI  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int TCW = $clog2(MAX_TRACKS + 1);
  localparam int DI  = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;
  localparam int DCW = $clog2(MAX_DETECTIONS + 1);
  localparam int KW  = (TCW > 5) ? TCW : 5;

  // ---- input fields
  opcode_t           in_op;
  logic [FRAME_W-1:0] in_start;
  logic [BW-1:0]     in_blob;
  logic              in_acc;

  assign in_op    = opcode_t'(in_tuser);
  assign in_start = in_tdata[15:0];
  assign in_blob  = {in_tdata[51:40], in_tdata[28 +: CW], in_tdata[16 +: CW]};
  assign in_acc   = in_tvalid && in_tready;

  // ---- configuration
  logic [FRAME_W-1:0] limit_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_FRAME_LIMIT) ? {16'b0, limit_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= FRAME_LIMIT_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == ADDR_FRAME_LIMIT) begin
      limit_r <= cfg_pwdata[15:0];
    end
  end

  // ---- control state
  fsm_state_t         state_r, state_nxt;
  logic [TCW-1:0]     trk_cnt_r, trk_cnt_nxt;
  logic [DCW-1:0]     det_cnt_r, det_cnt_nxt;
  logic [TCW-1:0]     i_r, i_nxt;
  logic [DCW-1:0]     j_r, j_nxt;
  logic [FRAME_W-1:0] fc_r, fc_nxt;
  logic               halted_r, halted_nxt;
  status_t            pend_stat_r, pend_stat_nxt;
  logic [IDX_W-1:0]   pend_idx_r, pend_idx_nxt;

  // ---- stores
  logic [BW-1:0] trk_mem [MAX_TRACKS];
  logic [BW-1:0] det_mem [MAX_DETECTIONS];
  logic [BW-1:0] mat_mem [MAX_TRACKS];
  logic [BW-1:0] trk_rd_r, det_rd_r, mat_rd_r;
  logic          trk_we, det_we, mat_we, trk_re, det_re, mat_re;
  logic [TI-1:0] trk_wa;
  logic [BW-1:0] trk_wd;

  // ---- output register
  logic               out_valid_r;
  status_t            out_stat_r, out_stat_nxt;
  logic [IDX_W-1:0]   out_idx_r, out_idx_nxt;
  logic [BW-1:0]      out_blob_r, out_blob_nxt;
  logic [FRAME_W-1:0] out_frame_r;
  logic               out_last_r, out_last_nxt;
  logic               out_load, slot_free;

  // ---- gate unit
  gate_res_t gate_res;
  logic      gate_start;

  logic [TCW-1:0] i_inc;
  logic           emit_trk, last_trk;

  assign slot_free = !out_valid_r || out_tready;
  assign i_inc     = TCW'(i_r + 1'b1);
  assign emit_trk  = KW'(i_r) < KW'(RESULT_CAP);
  assign last_trk  = (i_inc == trk_cnt_r) || (KW'(i_r) == KW'(RESULT_CAP - 1));
  assign in_tready = (state_r == FSM_IDLE);

  rgtm_gate #(
    .CW (CW)
  ) u_gate (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (gate_start),
    .trk_x    (trk_rd_r[CW-1:0]),
    .trk_y    (trk_rd_r[2*CW-1:CW]),
    .trk_size (trk_rd_r[BW-1:2*CW]),
    .det_x    (det_rd_r[CW-1:0]),
    .det_y    (det_rd_r[2*CW-1:CW]),
    .res      (gate_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      trk_cnt_r   <= '0;
      det_cnt_r   <= '0;
      i_r         <= '0;
      j_r         <= '0;
      fc_r        <= '0;
      halted_r    <= 1'b0;
      pend_stat_r <= STAT_TRACKED;
      pend_idx_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      trk_cnt_r   <= trk_cnt_nxt;
      det_cnt_r   <= det_cnt_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      fc_r        <= fc_nxt;
      halted_r    <= halted_nxt;
      pend_stat_r <= pend_stat_nxt;
      pend_idx_r  <= pend_idx_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    trk_cnt_nxt   = trk_cnt_r;
    det_cnt_nxt   = det_cnt_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    fc_nxt        = fc_r;
    halted_nxt    = halted_r;
    pend_stat_nxt = pend_stat_r;
    pend_idx_nxt  = pend_idx_r;
    trk_we        = 1'b0;
    trk_wa        = trk_cnt_r[TI-1:0];
    trk_wd        = in_blob;
    det_we        = 1'b0;
    mat_we        = 1'b0;
    trk_re        = 1'b0;
    det_re        = 1'b0;
    mat_re        = 1'b0;
    gate_start    = 1'b0;
    out_load      = 1'b0;
    out_stat_nxt  = pend_stat_r;
    out_idx_nxt   = pend_idx_r;
    out_blob_nxt  = '0;
    out_last_nxt  = 1'b1;

    unique case (state_r)
      FSM_IDLE: begin
        if (in_acc) begin
          unique case (in_op)
            OP_START: begin
              trk_cnt_nxt = '0;
              det_cnt_nxt = '0;
              fc_nxt      = in_start;
              halted_nxt  = 1'b0;
            end
            OP_ADD_TRACK: begin
              if (!halted_r && trk_cnt_r < TCW'(MAX_TRACKS)) begin
                trk_we      = 1'b1;
                trk_cnt_nxt = TCW'(trk_cnt_r + 1'b1);
              end
            end
            OP_ADD_DET: begin
              if (!halted_r && det_cnt_r < DCW'(MAX_DETECTIONS)) begin
                det_we      = 1'b1;
                det_cnt_nxt = DCW'(det_cnt_r + 1'b1);
              end
            end
            OP_END_FRAME: begin
              pend_idx_nxt = '0;
              if (halted_r) begin
                det_cnt_nxt   = '0;
                pend_stat_nxt = STAT_HALTED;
                state_nxt     = FSM_EMIT;
              end else if ({1'b0, fc_r} + 17'd1 >= {1'b0, limit_r}) begin
                det_cnt_nxt   = '0;
                pend_stat_nxt = STAT_LIMIT;
                state_nxt     = FSM_EMIT;
              end else if (trk_cnt_r == '0) begin
                det_cnt_nxt   = '0;
                fc_nxt        = fc_r + 1'b1;
                pend_stat_nxt = STAT_NO_TRACKS;
                state_nxt     = FSM_EMIT;
              end else begin
                i_nxt     = '0;
                j_nxt     = '0;
                state_nxt = FSM_SRCH_RD;
              end
            end
            default: state_nxt = FSM_IDLE;
          endcase
        end
      end
      FSM_SRCH_RD: begin
        if (j_r >= det_cnt_r) begin
          halted_nxt    = 1'b1;
          det_cnt_nxt   = '0;
          pend_stat_nxt = STAT_MISMATCH;
          pend_idx_nxt  = IDX_W'(i_r);
          state_nxt     = FSM_EMIT;
        end else begin
          trk_re    = 1'b1;
          det_re    = 1'b1;
          state_nxt = FSM_SRCH_WAIT;
        end
      end
      FSM_SRCH_WAIT: begin
        gate_start = 1'b1;
        state_nxt  = FSM_SRCH_GATE;
      end
      FSM_SRCH_GATE: begin
        if (gate_res.done) begin
          if (gate_res.hit) begin
            mat_we = 1'b1;
            j_nxt  = '0;
            if (i_inc == trk_cnt_r) begin
              det_cnt_nxt = '0;
              fc_nxt      = fc_r + 1'b1;
              i_nxt       = '0;
              state_nxt   = FSM_UPD_RD;
            end else begin
              i_nxt     = i_inc;
              state_nxt = FSM_SRCH_RD;
            end
          end else begin
            j_nxt     = DCW'(j_r + 1'b1);
            state_nxt = FSM_SRCH_RD;
          end
        end
      end
      FSM_UPD_RD: begin
        mat_re    = 1'b1;
        state_nxt = FSM_UPD_WR;
      end
      FSM_UPD_WR: begin
        if (!emit_trk || slot_free) begin
          trk_we       = 1'b1;
          trk_wa       = i_r[TI-1:0];
          trk_wd       = mat_rd_r;
          out_load     = emit_trk;
          out_stat_nxt = STAT_TRACKED;
          out_idx_nxt  = IDX_W'(i_r);
          out_blob_nxt = mat_rd_r;
          out_last_nxt = last_trk;
          if (i_inc == trk_cnt_r) begin
            state_nxt = FSM_IDLE;
          end else begin
            i_nxt     = i_inc;
            state_nxt = FSM_UPD_RD;
          end
        end
      end
      FSM_EMIT: begin
        if (slot_free) begin
          out_load  = 1'b1;
          state_nxt = FSM_IDLE;
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  // ---- memories
  always_ff @(posedge clk) begin
    if (trk_we) trk_mem[trk_wa] <= trk_wd;
    if (trk_re) trk_rd_r <= trk_mem[i_r[TI-1:0]];
  end

  always_ff @(posedge clk) begin
    if (det_we) det_mem[det_cnt_r[DI-1:0]] <= in_blob;
    if (det_re) det_rd_r <= det_mem[j_r[DI-1:0]];
  end

  always_ff @(posedge clk) begin
    if (mat_we) mat_mem[i_r[TI-1:0]] <= det_rd_r;
    if (mat_re) mat_rd_r <= mat_mem[i_r[TI-1:0]];
  end

  // ---- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_stat_r  <= out_stat_nxt;
      out_idx_r   <= out_idx_nxt;
      out_blob_r  <= out_blob_nxt;
      out_frame_r <= fc_r;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_stat_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {out_frame_r,
                       out_blob_r[BW-1:2*CW],
                       FIELD_W'(out_blob_r[2*CW-1:CW]),
                       FIELD_W'(out_blob_r[CW-1:0]),
                       out_idx_r};

  // ---- assertions
  `RGTM_ASSERT_NEXT(a_miss_halts, clk, rst_n,
    (state_r == FSM_SRCH_RD && j_r >= det_cnt_r), halted_r,
    "detection list exhausted without halting")
  `RGTM_ASSERT_SAME(a_upd_det_clear, clk, rst_n,
    (state_r == FSM_UPD_RD || state_r == FSM_UPD_WR), (det_cnt_r == '0),
    "detection buffer not emptied before track update")
  `RGTM_ASSERT_SAME(a_upd_in_range, clk, rst_n,
    (state_r == FSM_UPD_WR), (i_r < trk_cnt_r),
    "track update index beyond track count")
  `RGTM_ASSERT_SAME(a_gate_only_search, clk, rst_n,
    gate_res.done, (state_r == FSM_SRCH_GATE),
    "gate result outside the search walk")

endmodule

`default_nettype wire

@@ test/radius_gated_track_matcher_tb.sv @@
// ----------------------------------------------------------------------------
// radius_gated_track_matcher_tb
// Self-checking bench for the radius-gated track matcher. A short scripted
// sequence covers reset state, frame limit, gating boundaries, mismatch
// abort and the halted state. Random tracking sessions follow: random
// frame limits, track sets, detections placed inside each track's radius
// with noise, missed tracks and store overflow. Every result beat is
// compared with a behavioral tracker model kept in step with the input.
// ----------------------------------------------------------------------------
`default_nettype none

module radius_gated_track_matcher_tb
  import rgtm_pkg::*;
();

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [11:0] s;
  } blob_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  idx;
    logic [11:0] mx;
    logic [11:0] my;
    logic [11:0] ms;
    logic [15:0] frame;
    logic        last;
  } report_t;

  typedef struct packed {
    opcode_t     op;
    logic [15:0] sf;
    blob_t       b;
    logic        typed;
    report_t     rep;
  } step_t;

  localparam report_t NO_REP = '{STAT_TRACKED, 4'd0, 12'd0, 12'd0, 12'd0, 16'd0, 1'b0};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;   // start_frame, pos_x, pos_y, blob_size
  logic [1:0]  in_tuser = '0;   // opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;       // track_index, match_x, match_y, match_size,
                                // frame_number
  logic [2:0]  out_tuser;       // status
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  radius_gated_track_matcher DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // tracker model state
  blob_t       trk [DEF_MAX_TRACKS];
  blob_t       det [DEF_MAX_DETECTIONS];
  int          trk_n = 0;
  int          det_n = 0;
  logic [15:0] frame_ctr = '0;
  logic [15:0] limit_reg = FRAME_LIMIT_RST;
  bit          halted = 1'b0;

  report_t pending_reports [$];
  int      mismatches = 0;
  int      items_done = 0;
  int      burst_left = 0;
  int      rdy_mode = 0;
  int      rdy_left = 0;

  step_t script [21] = '{
    '{OP_END_FRAME, 16'h0000, '{12'd0, 12'd0, 12'd0}, 1'b1,
      '{STAT_NO_TRACKS, 4'd0, 12'd0, 12'd0, 12'd0, 16'd1, 1'b1}},
    '{OP_START, 16'hFFFF, '{12'd0, 12'd0, 12'd0}, 1'b0, NO_REP},
    '{OP_END_FRAME, 16'h0000, '{12'd0, 12'd0, 12'd0}, 1'b1,
      '{STAT_LIMIT, 4'd0, 12'd0, 12'd0, 12'd0, 16'hFFFF, 1'b1}},
    '{OP_START, 16'h0000, '{12'd0, 12'd0, 12'd0}, 1'b0, NO_REP},
    '{OP_ADD_TRACK, 16'h0000, '{12'd0, 12'd0, 12'd0}, 1'b0, NO_REP},
    '{OP_ADD_TRACK, 16'h0000, '{12'd4095, 12'd4095, 12'd4095}, 1'b0, NO_REP},
    '{OP_ADD_TRACK, 16'h0000, '{12'd100, 12'd200, 12'd5}, 1'b0, NO_REP},
    '{OP_ADD_DET, 16'h0000, '{12'd0, 12'd0, 12'd4095}, 1'b0, NO_REP},
    '{OP_ADD_DET, 16'h0000, '{12'd4095, 12'd4095, 12'd0}, 1'b0, NO_REP},
    '{OP_ADD_DET, 16'h0000, '{12'd103, 12'd204, 12'd7}, 1'b0, NO_REP},
    '{OP_END_FRAME, 16'h0000, '{12'd0, 12'd0, 12'd0}, 1'b0, NO_REP},
    '{OP_ADD_DET, 16'h0000, '{12'd110, 12'd204, 12'd1}, 1'b0, NO_REP},
    '{OP_END_FRAME, 16'h0000, '{12'd0, 12'd0, 12'd0}, 1'b1,
      '{STAT_MISMATCH, 4'd1, 12'd0, 12'd0, 12'd0, 16'd1, 1'b1}},
    '{OP_ADD_TRACK, 16'h0000, '{12'd1, 12'd1, 12'd1}, 1'b0, NO_REP},
    '{OP_END_FRAME, 16'h0000, '{12'd0, 12'd0, 12'd0}, 1'b1,
      '{STAT_HALTED, 4'd0, 12'd0, 12'd0, 12'd0, 16'd1, 1'b1}},
    '{OP_START, 16'h1234, '{12'd0, 12'd0, 12'd0}, 1'b0, NO_REP},
    '{OP_ADD_TRACK, 16'h0000, '{12'd2048, 12'd2048, 12'd3}, 1'b0, NO_REP},
    '{OP_ADD_DET, 16'h0000, '{12'd2051, 12'd2050, 12'd1}, 1'b0, NO_REP},
    '{OP_ADD_DET, 16'h0000, '{12'd2050, 12'd2050, 12'd9}, 1'b0, NO_REP},
    '{OP_END_FRAME, 16'h0000, '{12'd0, 12'd0, 12'd0}, 1'b1,
      '{STAT_TRACKED, 4'd0, 12'd2050, 12'd2050, 12'd9, 16'h1235, 1'b1}},
    '{OP_END_FRAME, 16'h0000, '{12'd0, 12'd0, 12'd0}, 1'b1,
      '{STAT_MISMATCH, 4'd0, 12'd0, 12'd0, 12'd0, 16'h1235, 1'b1}}
  };

  function automatic report_t make_report(status_t st, int idx, blob_t b, bit last);
    report_t r;
    r.status = st;
    r.idx    = idx[3:0];
    r.mx     = b.x;
    r.my     = b.y;
    r.ms     = b.s;
    r.frame  = frame_ctr;
    r.last   = last;
    return r;
  endfunction

  function automatic bit in_gate(blob_t t, blob_t d);
    int dx;
    int dy;
    dx = (t.x > d.x) ? int'(t.x - d.x) : int'(d.x - t.x);
    dy = (t.y > d.y) ? int'(t.y - d.y) : int'(d.y - t.y);
    return dx * dx + dy * dy <= int'(t.s) * int'(t.s);
  endfunction

  // applies one beat to the model, queues the reports it produces
  task automatic advance_tracker(input opcode_t op, input logic [15:0] sf, input blob_t b,
                                 output bit counted);
    int    pick [DEF_MAX_TRACKS];
    int    miss;
    bit    found;
    blob_t none;
    none    = '0;
    counted = 1'b1;
    case (op)
      OP_START: begin
        trk_n     = 0;
        det_n     = 0;
        frame_ctr = sf;
        halted    = 1'b0;
      end
      OP_ADD_TRACK: begin
        if (!halted && trk_n < DEF_MAX_TRACKS) begin
          trk[trk_n] = b;
          trk_n++;
        end else begin
          counted = 1'b0;
        end
      end
      OP_ADD_DET: begin
        if (!halted && det_n < DEF_MAX_DETECTIONS) begin
          det[det_n] = b;
          det_n++;
        end else begin
          counted = 1'b0;
        end
      end
      default: begin
        if (halted) begin
          det_n = 0;
          pending_reports.push_back(make_report(STAT_HALTED, 0, none, 1'b1));
        end else if ({1'b0, frame_ctr} + 17'd1 >= {1'b0, limit_reg}) begin
          det_n = 0;
          pending_reports.push_back(make_report(STAT_LIMIT, 0, none, 1'b1));
        end else begin
          miss = -1;
          for (int i = 0; i < trk_n && miss < 0; i++) begin
            found = 1'b0;
            for (int j = 0; j < det_n && !found; j++) begin
              if (in_gate(trk[i], det[j])) begin
                pick[i] = j;
                found   = 1'b1;
              end
            end
            if (!found) miss = i;
          end
          if (miss >= 0) begin
            halted = 1'b1;
            det_n  = 0;
            pending_reports.push_back(make_report(STAT_MISMATCH, miss, none, 1'b1));
          end else begin
            det_n     = 0;
            frame_ctr = frame_ctr + 16'd1;
            if (trk_n == 0) begin
              pending_reports.push_back(make_report(STAT_NO_TRACKS, 0, none, 1'b1));
            end else begin
              for (int i = 0; i < trk_n; i++) trk[i] = det[pick[i]];
              for (int k = 0; k < trk_n && k < RESULT_CAP; k++)
                pending_reports.push_back(make_report(STAT_TRACKED, k, trk[k],
                                                      k == trk_n - 1 || k == RESULT_CAP - 1));
            end
          end
        end
      end
    endcase
  endtask

  task automatic send_beat(input opcode_t op, input logic [15:0] sf, input blob_t b,
                           input bit typed, input report_t rep);
    bit counted;
    int n0;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'h0, b.s, b.y, b.x, sf};
    do @(posedge clk); while (!in_tready);
    n0 = pending_reports.size();
    advance_tracker(op, sf, b, counted);
    if (typed) begin
      while (pending_reports.size() > n0) void'(pending_reports.pop_back());
      pending_reports.push_back(rep);
    end
    if (counted) items_done++;
  endtask

  // sender holds off until every queued report has come back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_frame_limit(input logic [15:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_FRAME_LIMIT;
    cfg_pwdata  <= {16'h0000, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    limit_reg = v;
    // read back
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[15:0] !== v) begin
      $error("frame_limit readback: expected %0d, got %0d", v, cfg_prdata[15:0]);
      mismatches++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic logic [11:0] nudge(logic [11:0] c, int d);
    int v;
    v = $urandom_range(0, 1) ? int'(c) + d : int'(c) - d;
    if (v > 4095) v = 4095;
    if (v < 0) v = 0;
    return v[11:0];
  endfunction

  function automatic logic [11:0] rand_size();
    case ($urandom_range(0, 3))
      0:       return 12'($urandom_range(0, 4095));
      1:       return 12'($urandom_range(1, 40));
      default: return 12'($urandom_range(0, 255));
    endcase
  endfunction

  // detection that falls inside the track's radius (|dx| + |dy| <= r)
  function automatic blob_t near_blob(blob_t t);
    blob_t d;
    int    dx;
    int    dy;
    dx  = $urandom_range(0, t.s);
    dy  = $urandom_range(0, t.s - dx);
    d.x = nudge(t.x, dx);
    d.y = nudge(t.y, dy);
    d.s = rand_size();
    return d;
  endfunction

  function automatic blob_t rand_blob();
    blob_t b;
    b.x = 12'($urandom_range(0, 4095));
    b.y = 12'($urandom_range(0, 4095));
    b.s = rand_size();
    return b;
  endfunction

  // receiver stall pattern
  always @(posedge clk) begin
    if (rdy_left == 0) begin
      rdy_mode = $urandom_range(0, 3);
      rdy_left = (rdy_mode == 3) ? $urandom_range(1, 6) : $urandom_range(4, 40);
    end
    rdy_left--;
    case (rdy_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= (rdy_left % 3 != 0);
      default: out_tready <= 1'b0;
    endcase
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_results
    report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_reports.size() == 0) begin
        $error("result beat with nothing expected: status %0d", out_tuser);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        check_field("status", int'(want.status), int'(out_tuser));
        check_field("track_index", int'(want.idx), int'(out_tdata[3:0]));
        check_field("match_x", int'(want.mx), int'(out_tdata[15:4]));
        check_field("match_y", int'(want.my), int'(out_tdata[27:16]));
        check_field("match_size", int'(want.ms), int'(out_tdata[39:28]));
        check_field("frame_number", int'(want.frame), int'(out_tdata[55:40]));
        check_field("last", int'(want.last), int'(out_tlast));
      end
    end
  end

  initial begin : stimulus
    blob_t       dets [$];
    blob_t       b;
    logic [15:0] sf;
    logic [15:0] lim;
    int          session;
    int          ntr;
    int          nfr;
    int          miss_i;
    int          noise;
    bit          wrote;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[k])
      send_beat(script[k].op, script[k].sf, script[k].b, script[k].typed, script[k].rep);

    session = 0;
    while (items_done < 470) begin
      wait_idle();
      wrote = (session < 3) || ($urandom_range(0, 2) == 0);
      if (wrote) begin
        case (session)
          0: lim = 16'd0;
          1: lim = 16'hFFFF;
          2: lim = 16'd1;
          default: begin
            case ($urandom_range(0, 3))
              0:       lim = 16'hFFFF;
              1:       lim = 16'($urandom_range(0, 65535));
              2:       lim = 16'($urandom_range(2, 12));
              default: lim = 16'hFFFE;
            endcase
          end
        endcase
        write_frame_limit(lim);
        case ($urandom_range(0, 3))
          0:       sf = 16'($urandom_range(0, 65535));
          1:       sf = (lim > 4) ? 16'(lim - $urandom_range(1, 4)) : 16'd0;
          default: sf = 16'($urandom_range(0, (lim > 8) ? lim - 8 : 0));
        endcase
      end else begin
        sf = 16'($urandom_range(0, (limit_reg > 1) ? limit_reg - 2 : 0));
      end
      send_beat(OP_START, sf, rand_blob(), 1'b0, NO_REP);

      case ($urandom_range(0, 19))
        0:       ntr = 0;
        1:       ntr = $urandom_range(16, 18);
        default: ntr = $urandom_range(1, 5);
      endcase
      for (int i = 0; i < ntr; i++) send_beat(OP_ADD_TRACK, 16'h0, rand_blob(), 1'b0, NO_REP);

      nfr = $urandom_range(1, 6);
      for (int f = 0; f < nfr; f++) begin
        dets.delete();
        miss_i = ($urandom_range(0, 9) == 0 && trk_n > 0) ?
                 int'($urandom_range(0, trk_n - 1)) : -1;
        for (int i = 0; i < trk_n; i++)
          if (i != miss_i) dets.push_back(near_blob(trk[i]));
        noise = ($urandom_range(0, 24) == 0) ? 66 - dets.size() : int'($urandom_range(0, 3));
        for (int n = 0; n < noise; n++) dets.insert($urandom_range(0, dets.size()), rand_blob());
        foreach (dets[j]) send_beat(OP_ADD_DET, 16'h0, dets[j], 1'b0, NO_REP);
        if ($urandom_range(0, 39) == 0)
          send_beat(OP_START, 16'($urandom_range(0, 65535)), rand_blob(), 1'b0, NO_REP);
        if ($urandom_range(0, 7) == 0) wait_idle();
        b = rand_blob();
        send_beat(OP_END_FRAME, 16'($urandom_range(0, 65535)), b, 1'b0, NO_REP);
        if (halted && $urandom_range(0, 2) == 0)
          send_beat(OP_ADD_TRACK, 16'h0, rand_blob(), 1'b0, NO_REP);
      end
      session++;
    end

    wait_idle();
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #60_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/rgtm_pkg.sv
hw/rtl/rgtm_gate.sv
hw/rtl/radius_gated_track_matcher.sv
test/radius_gated_track_matcher_tb.sv
